>>> sv/windowed_two_stream_correlation_unit_macros.svh
// assertion macros for the windowed two-stream correlation unit
// expects clk and arst_n in the scope of each use
`ifndef WINDOWED_TWO_STREAM_CORRELATION_UNIT_MACROS_SVH
`define WINDOWED_TWO_STREAM_CORRELATION_UNIT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define WTSC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define WTSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/wtsc_pkg.sv
// shared types and constants of the windowed two-stream correlation unit
// no dependencies
package wtsc_pkg;

	// request kinds carried in the input tuser
	typedef enum logic [1:0] {
		REQ_A    = 2'd0,
		REQ_B    = 2'd1,
		REQ_EVAL = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	localparam int CNT_W = 10;
	localparam logic [CNT_W-1:0] WINDOW_RESET = 10'd100;
	localparam int CORR_W = 16;
	localparam int MAG_W = CORR_W - 1;
	localparam logic [MAG_W-1:0] MAG_MAX = 15'h7fff;
	localparam int QBITS = 16;
	localparam int MEAN_FRAC = 8;
	localparam int CFG_ADDR_W = 3;
	localparam logic REG_WINDOW = 1'b0;

	typedef enum logic [3:0] {
		B_IDLE,
		B_SUB,
		B_DIV_A,
		B_DIV_B,
		B_WALK,
		B_DRAIN,
		B_CHECK,
		B_CORR,
		B_RESULT
	} back_state_t;

	typedef enum logic [2:0] {
		C_IDLE,
		C_MUL_P,
		C_MUL_C,
		C_ADD_A,
		C_ADD_B,
		C_CMP,
		C_DONE
	} corr_state_t;

	// head of the front queue as seen by the back end
	typedef struct packed {
		logic valid;
		req_t req;
	} item_stat_t;

	// status of the correlation magnitude unit
	typedef struct packed {
		logic busy;
		logic done;
	} corr_stat_t;

endpackage

>>> sv/wtsc_front.sv
// front end: accepts input transactions, drops unknown requests, queues the rest
// depends on wtsc_pkg
module wtsc_front
	import wtsc_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  req_t                   in_req,
	input  logic [SAMPLE_BITS-1:0] in_sample,
	input  logic                   pop,
	output item_stat_t             head,
	output logic [SAMPLE_BITS-1:0] head_sample
);

	req_t                   req_q [2];
	logic [SAMPLE_BITS-1:0] smp_q [2];
	logic                   wr_q;
	logic                   rd_q;
	logic [1:0]             cnt_q;
	logic                   push;
	logic                   pop_ok;

	// classify: unknown requests are taken but never queued
	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready && (in_req != REQ_NONE);
	assign pop_ok = pop && (cnt_q != 2'd0);

	assign head.valid = (cnt_q != 2'd0);
	assign head.req = req_q[rd_q];
	assign head_sample = smp_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			req_q[wr_q] <= in_req;
			smp_q[wr_q] <= in_sample;
		end
	end

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop_ok) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, pop_ok})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> sv/wtsc_corr.sv
// correlation magnitude: exact floor(|cov| * 2^15 / sqrt(va * vb)), saturated
// shift-add multiplier then a bit-by-bit search; depends on wtsc_pkg
module wtsc_corr
	import wtsc_pkg::*;
#(
	parameter int AW = 62
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    cov_abs,
	input  logic [AW-1:0]    va,
	input  logic [AW-1:0]    vb,
	output corr_stat_t       stat,
	output logic [MAG_W-1:0] mag
);

	localparam int PRW = 2 * AW;
	localparam int CW = 2 * AW + 32;
	localparam int MCW = $clog2(AW);
	localparam int KW = $clog2(QBITS);

	corr_state_t      state_q;
	corr_state_t      state_d;
	logic [AW-1:0]    x_q;
	logic [AW-1:0]    y_q;
	logic [AW-1:0]    cov_q;
	logic [PRW-1:0]   acc_q;
	logic [PRW-1:0]   acc_nx;
	logic [MCW-1:0]   mcnt_q;
	logic [PRW-1:0]   p_q;
	logic [CW-1:0]    c_q;
	logic [CW-1:0]    t_q;
	logic [CW-1:0]    qp_q;
	logic [CW-1:0]    s_q;
	logic [QBITS-1:0] q_q;
	logic [KW-1:0]    k_q;
	logic [KW:0]      sh_qp;
	logic             fits;

	// shift-add step, multiplier bits taken from the top
	assign acc_nx = (acc_q << 1) + (y_q[AW-1] ? PRW'(x_q) : '0);
	assign sh_qp = {1'b0, k_q} + (KW + 1)'(1);
	assign fits = (s_q <= c_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			C_IDLE:  if (start) state_d = C_MUL_P;
			C_MUL_P: if (mcnt_q == '0) state_d = C_MUL_C;
			C_MUL_C: if (mcnt_q == '0) state_d = C_ADD_A;
			C_ADD_A: state_d = C_ADD_B;
			C_ADD_B: state_d = C_CMP;
			C_CMP:   state_d = (k_q == '0) ? C_DONE : C_ADD_A;
			C_DONE:  state_d = C_IDLE;
			default: state_d = C_IDLE;
		endcase
	end

	// status outputs
	always_comb begin
		stat.busy = (state_q != C_IDLE);
		stat.done = (state_q == C_DONE);
		mag = q_q[QBITS-1] ? MAG_MAX : q_q[QBITS-2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: begin
				if (start) begin
					x_q <= va;
					y_q <= vb;
					cov_q <= cov_abs;
					acc_q <= '0;
					mcnt_q <= MCW'(AW - 1);
				end
			end
			C_MUL_P: begin
				acc_q <= acc_nx;
				y_q <= y_q << 1;
				mcnt_q <= mcnt_q - 1'b1;
				if (mcnt_q == '0) begin
					p_q <= acc_nx;
					x_q <= cov_q;
					y_q <= cov_q;
					acc_q <= '0;
					mcnt_q <= MCW'(AW - 1);
				end
			end
			C_MUL_C: begin
				acc_q <= acc_nx;
				y_q <= y_q << 1;
				mcnt_q <= mcnt_q - 1'b1;
				if (mcnt_q == '0) begin
					c_q <= CW'(acc_nx) << 30;
					t_q <= '0;
					qp_q <= '0;
					q_q <= '0;
					k_q <= KW'(QBITS - 1);
				end
			end
			// trial square: t + 2^(k+1) q p + 2^2k p
			C_ADD_A: s_q <= t_q + (qp_q << sh_qp);
			C_ADD_B: s_q <= s_q + (CW'(p_q) << {k_q, 1'b0});
			C_CMP: begin
				if (fits) begin
					t_q <= s_q;
					qp_q <= qp_q + (CW'(p_q) << k_q);
					q_q[k_q] <= 1'b1;
				end
				k_q <= k_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> sv/wtsc_back.sv
// back end: sample stores, running sums, means, window walk and result register
// depends on wtsc_pkg and wtsc_corr
module wtsc_back
	import wtsc_pkg::*;
#(
	parameter int STORE_DEPTH = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [CNT_W-1:0]       window,
	input  logic                   cfg_clear,
	input  item_stat_t             head,
	input  logic [SAMPLE_BITS-1:0] head_sample,
	output logic                   pop,
	output logic                   res_valid,
	input  logic                   res_ready,
	output logic [CORR_W-1:0]      res_corr,
	output logic                   res_defined
);

	localparam int SB = SAMPLE_BITS;
	localparam int PW = $clog2(STORE_DEPTH);
	localparam int SUMW = SB + CNT_W;
	localparam int NW = SB + 19;
	localparam int MW = SB + 9;
	localparam int DW = SB + 10;
	localparam int AW = 2 * DW + CNT_W;
	localparam int XW = ((PW > CNT_W) ? PW : CNT_W) + 1;
	localparam int DCW = $clog2(NW);
	localparam logic [PW-1:0] LAST_SLOT = PW'(STORE_DEPTH - 1);
	localparam logic [XW-1:0] DEPTH_X = XW'(STORE_DEPTH);

	function automatic logic [PW-1:0] slot_inc(input logic [PW-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PW-1:0] slot_dec(input logic [PW-1:0] p);
		return (p == '0) ? LAST_SLOT : p - 1'b1;
	endfunction

	// slot that drops out of the window
	function automatic logic [PW-1:0] slot_back(input logic [PW-1:0] p,
			input logic [CNT_W-1:0] w);
		logic [XW-1:0] px;
		logic [XW-1:0] wx;
		logic [XW-1:0] rx;
		px = XW'(p);
		wx = XW'(w);
		rx = (px >= wx) ? px - wx : px + DEPTH_X - wx;
		return rx[PW-1:0];
	endfunction

	function automatic logic signed [SUMW-1:0] sext_sum(input logic [SB-1:0] v);
		return $signed({{(SUMW - SB){v[SB-1]}}, v});
	endfunction

	logic [SB-1:0] mem_a [STORE_DEPTH];
	logic [SB-1:0] mem_b [STORE_DEPTH];

	back_state_t state_q;
	back_state_t state_d;

	logic [PW-1:0]          wp_a_q;
	logic [PW-1:0]          wp_b_q;
	logic [CNT_W-1:0]       cnt_a_q;
	logic [CNT_W-1:0]       cnt_b_q;
	logic signed [SUMW-1:0] sum_a_q;
	logic signed [SUMW-1:0] sum_b_q;
	logic                   sub_b_q;
	logic [PW-1:0]          rd_addr_a;
	logic [PW-1:0]          rd_addr_b;
	logic [SB-1:0]          rd_a_s1;
	logic [SB-1:0]          rd_b_s1;

	logic [NW-1:0]    num_q;
	logic [CNT_W:0]   rem_q;
	logic [CNT_W:0]   dvs_q;
	logic             neg_q;
	logic [DCW-1:0]   dcnt_q;
	logic [CNT_W+1:0] dv_r;
	logic             dv_ge;
	logic [CNT_W+1:0] dv_sub;
	logic [NW-1:0]    num_nx;
	logic signed [MW-1:0] mean_nx;
	logic signed [MW-1:0] mean_a_q;
	logic signed [MW-1:0] mean_b_q;

	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] n_min;
	logic [PW-1:0]    pa_q;
	logic [PW-1:0]    pb_q;
	logic             v_s1;
	logic             v_s2;
	logic             v_s3;
	logic signed [DW-1:0]   da_s2;
	logic signed [DW-1:0]   db_s2;
	logic signed [2*DW-1:0] cab_s3;
	logic [2*DW-1:0]        caa_s3;
	logic [2*DW-1:0]        cbb_s3;
	logic signed [2*DW-1:0] sqa;
	logic signed [2*DW-1:0] sqb;
	logic signed [AW-1:0]   cov_q;
	logic [AW-1:0]          va_q;
	logic [AW-1:0]          vb_q;
	logic signed [DW-1:0]   xa;
	logic signed [DW-1:0]   xb;

	logic [AW-1:0]     cov_abs;
	logic              ok_q;
	logic [MAG_W-1:0]  mag_q;
	logic [MAG_W-1:0]  mag;
	corr_stat_t        cstat;
	logic              res_valid_q;
	logic [CORR_W-1:0] res_corr_q;
	logic              res_def_q;

	logic full_a;
	logic full_b;
	logic wr_a;
	logic wr_b;
	logic eval_go;
	logic walk_issue;
	logic corr_start;
	logic res_load;
	logic var_ok;

	assign full_a = (cnt_a_q >= window);
	assign full_b = (cnt_b_q >= window);
	assign n_min = (cnt_a_q < cnt_b_q) ? cnt_a_q : cnt_b_q;
	assign var_ok = (va_q != '0) && (vb_q != '0);
	assign cov_abs = cov_q[AW-1] ? AW'(-cov_q) : AW'(cov_q);

	// full-width squares of the deviations
	assign sqa = da_s2 * da_s2;
	assign sqb = db_s2 * db_s2;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (head.valid) begin
					unique case (head.req)
						REQ_A:    state_d = full_a ? B_SUB : B_IDLE;
						REQ_B:    state_d = full_b ? B_SUB : B_IDLE;
						REQ_EVAL: state_d = (n_min == '0) ? B_RESULT : B_DIV_A;
						default:  state_d = B_IDLE;
					endcase
				end
			end
			B_SUB:    state_d = B_IDLE;
			B_DIV_A:  if (dcnt_q == '0) state_d = B_DIV_B;
			B_DIV_B:  if (dcnt_q == '0) state_d = B_WALK;
			B_WALK:   if (n_q == CNT_W'(1)) state_d = B_DRAIN;
			B_DRAIN:  if (!v_s1 && !v_s2 && !v_s3) state_d = B_CHECK;
			B_CHECK:  state_d = var_ok ? B_CORR : B_RESULT;
			B_CORR:   if (cstat.done) state_d = B_RESULT;
			B_RESULT: if (!res_valid_q || res_ready) state_d = B_IDLE;
			default:  state_d = B_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop = (state_q == B_IDLE) && head.valid;
		wr_a = pop && (head.req == REQ_A);
		wr_b = pop && (head.req == REQ_B);
		eval_go = pop && (head.req == REQ_EVAL);
		walk_issue = (state_q == B_WALK);
		corr_start = (state_q == B_CHECK) && var_ok;
		res_load = (state_q == B_RESULT) && (!res_valid_q || res_ready);
		rd_addr_a = walk_issue ? pa_q : slot_back(wp_a_q, window);
		rd_addr_b = walk_issue ? pb_q : slot_back(wp_b_q, window);
	end

	// restoring divider step for the rounded means
	always_comb begin
		dv_r = {rem_q, num_q[NW-1]};
		dv_ge = (dv_r >= {1'b0, dvs_q});
		dv_sub = dv_r - {1'b0, dvs_q};
		num_nx = {num_q[NW-2:0], dv_ge};
		mean_nx = neg_q ? -$signed({1'b0, num_nx[MW-2:0]}) : $signed({1'b0, num_nx[MW-2:0]});
	end

	// sample stores, read data registered
	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[wp_a_q] <= head_sample;
		end
		if (wr_b) begin
			mem_b[wp_b_q] <= head_sample;
		end
		rd_a_s1 <= mem_a[rd_addr_a];
		rd_b_s1 <= mem_b[rd_addr_b];
	end

	// control state, pointers, counts and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			wp_a_q <= '0;
			wp_b_q <= '0;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
			sub_b_q <= 1'b0;
			dcnt_q <= '0;
			n_q <= '0;
			pa_q <= '0;
			pb_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			ok_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1 <= walk_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cfg_clear) begin
				cnt_a_q <= '0;
				cnt_b_q <= '0;
				sum_a_q <= '0;
				sum_b_q <= '0;
			end else begin
				if (wr_a) begin
					wp_a_q <= slot_inc(wp_a_q);
					sum_a_q <= sum_a_q + sext_sum(head_sample);
					cnt_a_q <= full_a ? window : cnt_a_q + 1'b1;
				end
				if (wr_b) begin
					wp_b_q <= slot_inc(wp_b_q);
					sum_b_q <= sum_b_q + sext_sum(head_sample);
					cnt_b_q <= full_b ? window : cnt_b_q + 1'b1;
				end
				// oldest sample leaves the sum
				if (state_q == B_SUB) begin
					if (sub_b_q) begin
						sum_b_q <= sum_b_q - sext_sum(rd_b_s1);
					end else begin
						sum_a_q <= sum_a_q - sext_sum(rd_a_s1);
					end
				end
			end
			if (pop) begin
				sub_b_q <= (head.req == REQ_B);
			end
			if (eval_go) begin
				n_q <= n_min;
				ok_q <= 1'b0;
				dcnt_q <= DCW'(NW - 1);
			end
			if ((state_q == B_DIV_A) || (state_q == B_DIV_B)) begin
				dcnt_q <= (dcnt_q == '0) ? DCW'(NW - 1) : dcnt_q - 1'b1;
			end
			if ((state_q == B_DIV_B) && (dcnt_q == '0)) begin
				pa_q <= slot_dec(wp_a_q);
				pb_q <= slot_dec(wp_b_q);
			end
			// backward walk from the last written slot
			if (walk_issue) begin
				pa_q <= slot_dec(pa_q);
				pb_q <= slot_dec(pb_q);
				n_q <= n_q - 1'b1;
			end
			if (state_q == B_CHECK) begin
				ok_q <= var_ok;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// mean divider and walk datapath
	always_ff @(posedge clk) begin
		if (eval_go) begin
			neg_q <= sum_a_q[SUMW-1];
			num_q <= (NW'(sum_a_q[SUMW-1] ? -sum_a_q : sum_a_q) << 9) + NW'(cnt_a_q);
			dvs_q <= {cnt_a_q, 1'b0};
			rem_q <= '0;
			cov_q <= '0;
			va_q <= '0;
			vb_q <= '0;
		end
		if ((state_q == B_DIV_A) || (state_q == B_DIV_B)) begin
			num_q <= num_nx;
			rem_q <= dv_ge ? dv_sub[CNT_W:0] : dv_r[CNT_W:0];
		end
		if ((state_q == B_DIV_A) && (dcnt_q == '0)) begin
			mean_a_q <= mean_nx;
			neg_q <= sum_b_q[SUMW-1];
			num_q <= (NW'(sum_b_q[SUMW-1] ? -sum_b_q : sum_b_q) << 9) + NW'(cnt_b_q);
			dvs_q <= {cnt_b_q, 1'b0};
			rem_q <= '0;
		end
		if ((state_q == B_DIV_B) && (dcnt_q == '0)) begin
			mean_b_q <= mean_nx;
		end
		// deviations, products, sums
		da_s2 <= xa;
		db_s2 <= xb;
		cab_s3 <= da_s2 * db_s2;
		caa_s3 <= unsigned'(sqa);
		cbb_s3 <= unsigned'(sqb);
		if (v_s3) begin
			cov_q <= cov_q + AW'(cab_s3);
			va_q <= va_q + {{(AW - 2 * DW){1'b0}}, caa_s3};
			vb_q <= vb_q + {{(AW - 2 * DW){1'b0}}, cbb_s3};
		end
		if (cstat.done) begin
			mag_q <= mag;
		end
		if (res_load) begin
			res_def_q <= ok_q;
			if (!ok_q) begin
				res_corr_q <= '0;
			end else if (cov_q[AW-1]) begin
				res_corr_q <= -{1'b0, mag_q};
			end else begin
				res_corr_q <= {1'b0, mag_q};
			end
		end
	end

	// sample * 256 minus the stream mean
	always_comb begin
		xa = $signed({{(DW - SB - MEAN_FRAC){rd_a_s1[SB-1]}}, rd_a_s1, {MEAN_FRAC{1'b0}}})
			- $signed({{(DW - MW){mean_a_q[MW-1]}}, mean_a_q});
		xb = $signed({{(DW - SB - MEAN_FRAC){rd_b_s1[SB-1]}}, rd_b_s1, {MEAN_FRAC{1'b0}}})
			- $signed({{(DW - MW){mean_b_q[MW-1]}}, mean_b_q});
	end

	wtsc_corr #(
		.AW(AW)
	) u_corr (
		.clk(clk),
		.arst_n(arst_n),
		.start(corr_start),
		.cov_abs(cov_abs),
		.va(va_q),
		.vb(vb_q),
		.stat(cstat),
		.mag(mag)
	);

	assign res_valid = res_valid_q;
	assign res_corr = res_corr_q;
	assign res_defined = res_def_q;

endmodule

>>> sv/windowed_two_stream_correlation_unit.sv
// top level of the windowed two-stream correlation unit: config register and wiring
// depends on wtsc_pkg, wtsc_front and wtsc_back
//
// Input stream: s_tuser selects the request (stream A sample, stream B sample,
// evaluate; the fourth code is taken and dropped), s_tdata carries the sample.
// Each sample enters its stream's ring store, running sum and fill count,
// capped at window_length. An evaluate returns one transaction on the output
// stream: Pearson correlation of the newest min(count A, count B) samples in
// Q1.15 on m_tdata and the defined flag on m_tuser.
// A sample is taken in the idle state; when the window is full the back end also
// passes through a subtract state (the oldest sample, read back from its store,
// leaves the sum). An evaluate runs the two mean divisions of SAMPLE_BITS+19
// quotient bits each, the window walk (one store read per cycle), then two
// shift-add multiplications of AW bits and the 16-bit magnitude search,
// AW = 2*SAMPLE_BITS+30.
// A two-entry queue in front absorbs up to two transactions while the back end
// works, then s_tready drops; a stalled receiver holds the result register,
// and the back end stalls at its next result while the queue fills. Reset
// clears counts, sums and pointers and sets the window to 100 (lowered to the
// clamp limit for small stores); the stores have no clearing pass.
// Writing window_length (APB, byte address 0) clears counts and sums.
module windowed_two_stream_correlation_unit
	import wtsc_pkg::*;
#(
	parameter int STORE_DEPTH = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// sample
	input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// req_type
	input  logic [1:0]                               s_tuser,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// correlation
	output logic [CORR_W-1:0]                        m_tdata,
	// defined
	output logic [0:0]                               m_tuser,
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic [CFG_ADDR_W-1:0]                    paddr,
	input  logic [31:0]                              pwdata,
	output logic [31:0]                              prdata,
	output logic                                     pready
);

	localparam logic [CNT_W-1:0] WIN_MAX =
		(STORE_DEPTH - 1 > 1023) ? 10'd1023 : CNT_W'(STORE_DEPTH - 1);
	localparam logic [CNT_W-1:0] WIN_INIT =
		(WINDOW_RESET > WIN_MAX) ? WIN_MAX : WINDOW_RESET;

	logic [CNT_W-1:0]       window_q;
	logic [CNT_W-1:0]       win_wr;
	logic                   reg_hit;
	logic                   cfg_wr;
	item_stat_t             head;
	logic [SAMPLE_BITS-1:0] head_sample;
	logic                   pop;
	logic                   res_def;

	// register write, window clamped to 1 .. min(depth-1, 1023)
	assign pready = 1'b1;
	assign reg_hit = (paddr[CFG_ADDR_W-1] == REG_WINDOW);
	assign cfg_wr = psel && penable && pwrite && pready && reg_hit;
	always_comb begin
		win_wr = pwdata[CNT_W-1:0];
		if (win_wr == '0) begin
			win_wr = CNT_W'(1);
		end else if (win_wr > WIN_MAX) begin
			win_wr = WIN_MAX;
		end
	end
	assign prdata = reg_hit ? {{(32 - CNT_W){1'b0}}, window_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_INIT;
		end else if (cfg_wr) begin
			window_q <= win_wr;
		end
	end

	wtsc_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_req(req_t'(s_tuser)),
		.in_sample(s_tdata[SAMPLE_BITS-1:0]),
		.pop(pop),
		.head(head),
		.head_sample(head_sample)
	);

	wtsc_back #(
		.STORE_DEPTH(STORE_DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.window(window_q),
		.cfg_clear(cfg_wr),
		.head(head),
		.head_sample(head_sample),
		.pop(pop),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res_corr(m_tdata),
		.res_defined(res_def)
	);

	assign m_tuser = res_def;

endmodule

>>> sv/wtsc_checker.sv
// port-level checks on the result stream of the correlation unit
// depends on the assertion macro header; bound to the top level below
`include "windowed_two_stream_correlation_unit_macros.svh"

module wtsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// a stalled result stays and holds its payload
	`WTSC_ASSERT_NEXT(a_res_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`WTSC_ASSERT_NEXT(a_res_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// undefined results read zero
	`WTSC_ASSERT_SAME(a_undef_zero, m_tvalid && !m_tuser[0], m_tdata == 16'h0000, "undefined result not zero")

	// saturation keeps the magnitude at or below full scale
	`WTSC_ASSERT_SAME(a_sat_range, m_tvalid, m_tdata != 16'h8000, "correlation outside saturated range")

endmodule

bind windowed_two_stream_correlation_unit wtsc_checker u_wtsc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser)
);
